// ===== src/polygon_vertex_snap_core_macros.svh =====
// assertion macros for the polygon vertex snap core
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef POLYGON_VERTEX_SNAP_CORE_MACROS_SVH
`define POLYGON_VERTEX_SNAP_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define PVS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pvs same-cycle check failed");

// next-cycle implication, disabled during reset
`define PVS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pvs next-cycle check failed");

`endif

// ===== src/pvs_pkg.sv =====
// shared types, widths and codes of the polygon vertex snap core
// no dependencies
package pvs_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = 17;
  localparam int MUL_W   = 18;
  localparam int PROD_W  = 36;
  localparam int ACC_W   = 54;
  localparam int DIST_W  = 35;
  localparam int NUM_W   = 36;
  localparam int DEN_W   = 35;
  localparam int DVD_W   = 54;
  localparam int DVS_W   = 36;
  localparam int Q_W     = 18;
  localparam int THR_W   = 15;
  localparam int KIND_W  = 2;
  localparam int CIDX_W  = 2;
  localparam int HI_SHIFT = 17;

  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VERTEX = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SNAP = 1'b1;

  localparam logic [CIDX_W-1:0] REG_VERTEX_THR = 2'd0;
  localparam logic [CIDX_W-1:0] REG_EDGE_THR   = 2'd1;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quotient;
  } div_rsp_t;

  // signed difference of two Q11.4 coordinates, one bit wider
  function automatic logic signed [DIFF_W-1:0] coord_diff(
    input logic [COORD_W-1:0] a,
    input logic [COORD_W-1:0] b
  );
    coord_diff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

endpackage

// ===== src/pvs_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module pvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pvs_div.sv =====
// restoring divider, one quotient bit per cycle, for the edge projection
// depends on pvs_pkg
module pvs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pvs_pkg::div_req_t  req_i,
  output pvs_pkg::div_rsp_t  rsp_o
);

  localparam int CNT_W = $clog2(pvs_pkg::Q_W);

  logic                        busy_q;
  logic                        done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [pvs_pkg::DVD_W-1:0]   rem_q;
  logic [pvs_pkg::DVD_W-1:0]   dsh_q;
  logic [pvs_pkg::Q_W-1:0]     quo_q;
  logic                        fits;

  assign fits = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsh_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= req_i.dividend;
        dsh_q  <= pvs_pkg::DVD_W'(req_i.divisor) << (pvs_pkg::Q_W - 1);
        quo_q  <= '0;
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= rem_q - dsh_q;
        end
        quo_q <= {quo_q[pvs_pkg::Q_W-2:0], fits};
        dsh_q <= dsh_q >> 1;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(pvs_pkg::Q_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== src/polygon_vertex_snap_core.sv =====
// polygon vertex snap core: a load never raises busy.
// a snap first compares the point with every stored vertex; when no vertex is near
// enough, it goes on to every edge of the polygon; both passes use the shared
// 18x18 multiply-accumulate unit, and the edge projection the bit-serial divider.
// results are strobed on done_o for one cycle; the receiver cannot stall.
// reset: store empty, polygon closed, thresholds zero; ram contents undefined.
`include "polygon_vertex_snap_core_macros.svh"

module polygon_vertex_snap_core #(
  parameter int MAX_REF_VERTICES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [pvs_pkg::COORD_W-1:0]   point_x_i,
  input  logic [pvs_pkg::COORD_W-1:0]   point_y_i,
  input  logic                          last_vertex_i,
  // result channel
  output logic                          done_o,
  output logic [pvs_pkg::COORD_W-1:0]   snapped_x_o,
  output logic [pvs_pkg::COORD_W-1:0]   snapped_y_o,
  output logic [pvs_pkg::KIND_W-1:0]    snap_kind_o,
  output logic                          ref_truncated_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pvs_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [pvs_pkg::THR_W-1:0]     cfg_data_i
);

  localparam int ADDR_W = $clog2(MAX_REF_VERTICES);
  localparam int CNT_W  = $clog2(MAX_REF_VERTICES + 1);
  localparam int CW     = pvs_pkg::COORD_W;

  typedef enum logic [5:0] {
    S_IDLE, S_V_RD, S_V_SQ0, S_V_SQ1, S_V_CMP, S_V_TH, S_V_DEC,
    S_E_RD0, S_E_FIRST, S_E_NEXT, S_E_LOAD,
    S_E_DEN0, S_E_DEN1, S_E_NUM0, S_E_NUM1, S_E_SEL,
    S_E_DA0, S_E_DA1, S_E_DB0, S_E_DB1, S_E_END,
    S_E_PX0, S_E_PX1, S_E_DVX, S_E_WX,
    S_E_PY0, S_E_PY1, S_E_DVY, S_E_WY,
    S_E_D0, S_E_D1, S_E_CMP, S_E_TH, S_E_DEC
  } state_e;

  typedef enum logic [1:0] {
    MUL_NONE, MUL_LOAD, MUL_ADD, MUL_ADD_HI
  } mul_mode_e;

  // control and configuration state
  state_e                       state_q;
  logic [CNT_W-1:0]             ref_count_q;
  logic                         closed_q;
  logic                         overflow_q;
  logic [pvs_pkg::THR_W-1:0]    vthr_q;
  logic [pvs_pkg::THR_W-1:0]    ethr_q;
  logic [CNT_W-1:0]             idx_q;
  logic                         last_edge_q;

  // working registers of one snap
  logic [CW-1:0]                c_x_q, c_y_q;
  logic [CW-1:0]                a_x_q, a_y_q;
  logic [CW-1:0]                b_x_q, b_y_q;
  logic [CW-1:0]                f_x_q, f_y_q;
  logic [CW-1:0]                cur_x_q, cur_y_q;
  logic [CW-1:0]                cand_x_q, cand_y_q;
  logic [CW-1:0]                best_x_q, best_y_q;
  logic [pvs_pkg::DIST_W-1:0]   best_q;
  logic [pvs_pkg::DIST_W-1:0]   da_q;
  logic [pvs_pkg::DEN_W-1:0]    den_q;
  logic [pvs_pkg::NUM_W-1:0]    num_q;
  logic                         p_neg_q;
  logic signed [pvs_pkg::ACC_W-1:0] acc_q;

  // result registers
  logic                         done_q;
  logic [CW-1:0]                res_x_q, res_y_q;
  logic [pvs_pkg::KIND_W-1:0]   res_kind_q;
  logic                         res_trunc_q;

  // ram ports
  logic                         ram_we, ram_re;
  logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
  logic [2*CW-1:0]              ram_rdata;
  logic [CW-1:0]                ram_x, ram_y;

  // shared multiply-accumulate unit
  logic signed [pvs_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [pvs_pkg::PROD_W-1:0] prod;
  logic signed [pvs_pkg::ACC_W-1:0]  prod_ext;
  mul_mode_e                         mul_mode;

  // divider
  pvs_pkg::div_req_t            div_req;
  pvs_pkg::div_rsp_t            div_rsp;

  // operand differences
  logic signed [pvs_pkg::DIFF_W-1:0] ex, ey, wx, wy, bdx, bdy, vdx, vdy, cdx, cdy;

  logic                         accept;
  logic [CNT_W-1:0]             eff_count;
  logic                         acc_neg;
  logic                         num_gt_den;
  logic [pvs_pkg::DIST_W-1:0]   acc_dist;
  logic [pvs_pkg::ACC_W-1:0]    abs_p;
  logic signed [pvs_pkg::Q_W:0] q_signed;
  logic signed [CW+2:0]         proj_x, proj_y;

  assign accept    = start && (state_q == S_IDLE);
  assign eff_count = closed_q ? '0 : ref_count_q;

  assign ram_x = ram_rdata[CW-1:0];
  assign ram_y = ram_rdata[2*CW-1:CW];

  // a load goes straight into the store in the cycle it is taken, unless the store is full
  assign ram_we    = accept && (op_i == pvs_pkg::OP_LOAD)
                     && (eff_count < CNT_W'(MAX_REF_VERTICES));
  assign ram_waddr = eff_count[ADDR_W-1:0];

  // vertices are read strictly in order for both passes
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_q[ADDR_W-1:0];
    case (state_q)
      S_V_RD:   ram_re = 1'b1;
      S_E_RD0: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      S_E_NEXT: ram_re = (idx_q != ref_count_q);
      default:  ram_re = 1'b0;
    endcase
  end

  pvs_ram #(
    .WIDTH (2 * CW),
    .DEPTH (MAX_REF_VERTICES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({point_y_i, point_x_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ex  = pvs_pkg::coord_diff(b_x_q, a_x_q);
  assign ey  = pvs_pkg::coord_diff(b_y_q, a_y_q);
  assign wx  = pvs_pkg::coord_diff(c_x_q, a_x_q);
  assign wy  = pvs_pkg::coord_diff(c_y_q, a_y_q);
  assign bdx = pvs_pkg::coord_diff(c_x_q, b_x_q);
  assign bdy = pvs_pkg::coord_diff(c_y_q, b_y_q);
  assign vdx = pvs_pkg::coord_diff(c_x_q, ram_x);
  assign vdy = pvs_pkg::coord_diff(c_y_q, ram_y);
  assign cdx = pvs_pkg::coord_diff(c_x_q, cand_x_q);
  assign cdy = pvs_pkg::coord_diff(c_y_q, cand_y_q);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_mode = MUL_NONE;
    case (state_q)
      S_V_SQ0: begin
        mul_a = {vdx[16], vdx}; mul_b = {vdx[16], vdx}; mul_mode = MUL_LOAD;
      end
      S_V_SQ1: begin
        mul_a = {vdy[16], vdy}; mul_b = {vdy[16], vdy}; mul_mode = MUL_ADD;
      end
      S_V_TH: begin
        mul_a = {3'b000, vthr_q}; mul_b = {3'b000, vthr_q}; mul_mode = MUL_LOAD;
      end
      S_E_TH: begin
        mul_a = {3'b000, ethr_q}; mul_b = {3'b000, ethr_q}; mul_mode = MUL_LOAD;
      end
      S_E_DEN0: begin
        mul_a = {ex[16], ex}; mul_b = {ex[16], ex}; mul_mode = MUL_LOAD;
      end
      S_E_DEN1: begin
        mul_a = {ey[16], ey}; mul_b = {ey[16], ey}; mul_mode = MUL_ADD;
      end
      S_E_NUM0: begin
        mul_a = {wx[16], wx}; mul_b = {ex[16], ex}; mul_mode = MUL_LOAD;
      end
      S_E_NUM1: begin
        mul_a = {wy[16], wy}; mul_b = {ey[16], ey}; mul_mode = MUL_ADD;
      end
      S_E_DA0: begin
        mul_a = {wx[16], wx}; mul_b = {wx[16], wx}; mul_mode = MUL_LOAD;
      end
      S_E_DA1: begin
        mul_a = {wy[16], wy}; mul_b = {wy[16], wy}; mul_mode = MUL_ADD;
      end
      S_E_DB0: begin
        mul_a = {bdx[16], bdx}; mul_b = {bdx[16], bdx}; mul_mode = MUL_LOAD;
      end
      S_E_DB1: begin
        mul_a = {bdy[16], bdy}; mul_b = {bdy[16], bdy}; mul_mode = MUL_ADD;
      end
      // numerator split in two unsigned halves of 17 bits
      S_E_PX0: begin
        mul_a = {ex[16], ex}; mul_b = {1'b0, num_q[16:0]}; mul_mode = MUL_LOAD;
      end
      S_E_PX1: begin
        mul_a = {ex[16], ex}; mul_b = {1'b0, num_q[33:17]}; mul_mode = MUL_ADD_HI;
      end
      S_E_PY0: begin
        mul_a = {ey[16], ey}; mul_b = {1'b0, num_q[16:0]}; mul_mode = MUL_LOAD;
      end
      S_E_PY1: begin
        mul_a = {ey[16], ey}; mul_b = {1'b0, num_q[33:17]}; mul_mode = MUL_ADD_HI;
      end
      S_E_D0: begin
        mul_a = {cdx[16], cdx}; mul_b = {cdx[16], cdx}; mul_mode = MUL_LOAD;
      end
      S_E_D1: begin
        mul_a = {cdy[16], cdy}; mul_b = {cdy[16], cdy}; mul_mode = MUL_ADD;
      end
      default: mul_mode = MUL_NONE;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = {{(pvs_pkg::ACC_W - pvs_pkg::PROD_W){prod[pvs_pkg::PROD_W-1]}}, prod};

  assign acc_neg    = acc_q[pvs_pkg::ACC_W-1];
  assign acc_dist   = acc_q[pvs_pkg::DIST_W-1:0];
  assign num_gt_den = !acc_neg
                      && (acc_q[pvs_pkg::ACC_W-2:0] > (pvs_pkg::ACC_W - 1)'(den_q));
  assign abs_p      = acc_neg ? pvs_pkg::ACC_W'(-acc_q) : pvs_pkg::ACC_W'(acc_q);

  // rounded quotient: (2|p| + den) / (2 den)
  always_comb begin
    div_req.start    = (state_q == S_E_DVX) || (state_q == S_E_DVY);
    div_req.dividend = (abs_p << 1) + pvs_pkg::DVD_W'(den_q);
    div_req.divisor  = {den_q, 1'b0};
  end

  pvs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign q_signed = p_neg_q ? -$signed({1'b0, div_rsp.quotient})
                            : $signed({1'b0, div_rsp.quotient});
  assign proj_x   = $signed({{3{a_x_q[CW-1]}}, a_x_q}) + (CW + 3)'(q_signed);
  assign proj_y   = $signed({{3{a_y_q[CW-1]}}, a_y_q}) + (CW + 3)'(q_signed);

  // sequencer, state and registered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ref_count_q <= '0;
      closed_q    <= 1'b1;
      overflow_q  <= 1'b0;
      vthr_q      <= '0;
      ethr_q      <= '0;
      idx_q       <= '0;
      last_edge_q <= 1'b0;
      c_x_q <= '0; c_y_q <= '0; a_x_q <= '0; a_y_q <= '0;
      b_x_q <= '0; b_y_q <= '0; f_x_q <= '0; f_y_q <= '0;
      cur_x_q <= '0; cur_y_q <= '0; cand_x_q <= '0; cand_y_q <= '0;
      best_x_q <= '0; best_y_q <= '0;
      best_q  <= '1;
      da_q    <= '0;
      den_q   <= '0;
      num_q   <= '0;
      p_neg_q <= 1'b0;
      acc_q   <= '0;
      done_q  <= 1'b0;
      res_x_q <= '0; res_y_q <= '0;
      res_kind_q  <= pvs_pkg::KIND_NONE;
      res_trunc_q <= 1'b0;
    end else begin
      done_q <= 1'b0;

      // configuration writes, taken in any cycle
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          pvs_pkg::REG_VERTEX_THR: vthr_q <= cfg_data_i;
          pvs_pkg::REG_EDGE_THR:   ethr_q <= cfg_data_i;
          default: ;
        endcase
      end

      // shared multiply-accumulate
      case (mul_mode)
        MUL_LOAD:   acc_q <= prod_ext;
        MUL_ADD:    acc_q <= acc_q + prod_ext;
        MUL_ADD_HI: acc_q <= acc_q + (prod_ext <<< pvs_pkg::HI_SHIFT);
        default:    acc_q <= acc_q;
      endcase

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (op_i == pvs_pkg::OP_LOAD) begin
              // a load after a closed polygon starts a fresh one
              if (eff_count < CNT_W'(MAX_REF_VERTICES)) begin
                ref_count_q <= eff_count + 1'b1;
                overflow_q  <= closed_q ? 1'b0 : overflow_q;
              end else begin
                ref_count_q <= eff_count;
                overflow_q  <= 1'b1;
              end
              closed_q <= last_vertex_i;
            end else begin
              c_x_q  <= point_x_i;
              c_y_q  <= point_y_i;
              idx_q  <= '0;
              best_q <= '1;
              if (ref_count_q == '0) begin
                // empty store: point comes back unchanged
                done_q      <= 1'b1;
                res_x_q     <= point_x_i;
                res_y_q     <= point_y_i;
                res_kind_q  <= pvs_pkg::KIND_NONE;
                res_trunc_q <= overflow_q;
              end else begin
                state_q <= S_V_RD;
              end
            end
          end
        end

        // vertex pass
        S_V_RD:  state_q <= S_V_SQ0;
        S_V_SQ0: begin
          cur_x_q <= ram_x;
          cur_y_q <= ram_y;
          state_q <= S_V_SQ1;
        end
        S_V_SQ1: state_q <= S_V_CMP;
        S_V_CMP: begin
          // strict less-than keeps the first minimum
          if (acc_dist < best_q) begin
            best_q   <= acc_dist;
            best_x_q <= cur_x_q;
            best_y_q <= cur_y_q;
          end
          if (CNT_W'(idx_q + 1'b1) == ref_count_q) begin
            state_q <= S_V_TH;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_V_RD;
          end
        end
        S_V_TH:  state_q <= S_V_DEC;
        S_V_DEC: begin
          if (best_q < acc_dist) begin
            done_q      <= 1'b1;
            res_x_q     <= best_x_q;
            res_y_q     <= best_y_q;
            res_kind_q  <= pvs_pkg::KIND_VERTEX;
            res_trunc_q <= overflow_q;
            state_q     <= S_IDLE;
          end else begin
            best_q      <= '1;
            best_x_q    <= c_x_q;
            best_y_q    <= c_y_q;
            last_edge_q <= 1'b0;
            state_q     <= S_E_RD0;
          end
        end

        // edge pass: a is the previous vertex, b the current one
        S_E_RD0:   state_q <= S_E_FIRST;
        S_E_FIRST: begin
          f_x_q   <= ram_x;
          f_y_q   <= ram_y;
          a_x_q   <= ram_x;
          a_y_q   <= ram_y;
          idx_q   <= CNT_W'(1);
          state_q <= S_E_NEXT;
        end
        S_E_NEXT: begin
          if (idx_q == ref_count_q) begin
            // closing edge back to the first vertex
            b_x_q       <= f_x_q;
            b_y_q       <= f_y_q;
            last_edge_q <= 1'b1;
            state_q     <= S_E_DEN0;
          end else begin
            state_q <= S_E_LOAD;
          end
        end
        S_E_LOAD: begin
          b_x_q   <= ram_x;
          b_y_q   <= ram_y;
          state_q <= S_E_DEN0;
        end
        S_E_DEN0: state_q <= S_E_DEN1;
        S_E_DEN1: state_q <= S_E_NUM0;
        S_E_NUM0: begin
          den_q   <= acc_q[pvs_pkg::DEN_W-1:0];
          state_q <= S_E_NUM1;
        end
        S_E_NUM1: state_q <= S_E_SEL;
        S_E_SEL: begin
          num_q <= acc_q[pvs_pkg::NUM_W-1:0];
          if (den_q == '0) begin
            // zero-length edge gives its start point
            cand_x_q <= a_x_q;
            cand_y_q <= a_y_q;
            state_q  <= S_E_D0;
          end else if (acc_neg || num_gt_den) begin
            state_q <= S_E_DA0;
          end else begin
            state_q <= S_E_PX0;
          end
        end
        S_E_DA0: state_q <= S_E_DA1;
        S_E_DA1: state_q <= S_E_DB0;
        S_E_DB0: begin
          da_q    <= acc_dist;
          state_q <= S_E_DB1;
        end
        S_E_DB1: state_q <= S_E_END;
        S_E_END: begin
          // nearer endpoint, second one on a tie
          if (da_q < acc_dist) begin
            cand_x_q <= a_x_q;
            cand_y_q <= a_y_q;
          end else begin
            cand_x_q <= b_x_q;
            cand_y_q <= b_y_q;
          end
          state_q <= S_E_D0;
        end
        S_E_PX0: state_q <= S_E_PX1;
        S_E_PX1: state_q <= S_E_DVX;
        S_E_DVX: begin
          p_neg_q <= acc_neg;
          state_q <= S_E_WX;
        end
        S_E_WX: begin
          if (div_rsp.done) begin
            cand_x_q <= proj_x[CW-1:0];
            state_q  <= S_E_PY0;
          end
        end
        S_E_PY0: state_q <= S_E_PY1;
        S_E_PY1: state_q <= S_E_DVY;
        S_E_DVY: begin
          p_neg_q <= acc_neg;
          state_q <= S_E_WY;
        end
        S_E_WY: begin
          if (div_rsp.done) begin
            cand_y_q <= proj_y[CW-1:0];
            state_q  <= S_E_D0;
          end
        end
        S_E_D0: state_q <= S_E_D1;
        S_E_D1: state_q <= S_E_CMP;
        S_E_CMP: begin
          if (acc_dist < best_q) begin
            best_q   <= acc_dist;
            best_x_q <= cand_x_q;
            best_y_q <= cand_y_q;
          end
          if (last_edge_q) begin
            state_q <= S_E_TH;
          end else begin
            a_x_q   <= b_x_q;
            a_y_q   <= b_y_q;
            idx_q   <= idx_q + 1'b1;
            state_q <= S_E_NEXT;
          end
        end
        S_E_TH:  state_q <= S_E_DEC;
        S_E_DEC: begin
          done_q      <= 1'b1;
          res_trunc_q <= overflow_q;
          if (best_q < acc_dist) begin
            res_x_q    <= best_x_q;
            res_y_q    <= best_y_q;
            res_kind_q <= pvs_pkg::KIND_EDGE;
          end else begin
            res_x_q    <= c_x_q;
            res_y_q    <= c_y_q;
            res_kind_q <= pvs_pkg::KIND_NONE;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign snapped_x_o     = res_x_q;
  assign snapped_y_o     = res_y_q;
  assign snap_kind_o     = res_kind_q;
  assign ref_truncated_o = res_trunc_q;

  // checks on the sequencer
  `PVS_ASSERT_IMP(a_count_bound, 1'b1, ref_count_q <= CNT_W'(MAX_REF_VERTICES))
  `PVS_ASSERT_IMP(a_done_idle, done_o, state_q == S_IDLE)
  `PVS_ASSERT_IMP(a_snap_needs_store, done_o && (snap_kind_o != pvs_pkg::KIND_NONE), ref_count_q != '0)
  `PVS_ASSERT_NXT(a_snap_busy, accept && (op_i == pvs_pkg::OP_SNAP) && (ref_count_q != '0), busy)

endmodule
